### hw/rtl/lwps_pkg.sv
// shared types and constants for the display window and pixel framer
// no dependencies; used by lwps_byte_sel and lcd_window_pixel_streamer
package lwps_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS     = 25;
    localparam int BYTE_BITS      = 8;
    localparam int STEP_BITS      = 4;
    localparam int CFG_IDX_BITS   = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_CMD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_CMD    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_CMD  = 2'd2;

    localparam logic [BYTE_BITS-1:0] COLUMN_CMD_RST = 8'h2A;
    localparam logic [BYTE_BITS-1:0] ROW_CMD_RST    = 8'h2B;
    localparam logic [BYTE_BITS-1:0] WRITE_CMD_RST  = 8'h2C;

    // byte positions within a window request
    localparam logic [STEP_BITS-1:0] STEP_CMD_COL = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_XS_HI   = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_XS_LO   = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_XE_HI   = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_XE_LO   = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_CMD_ROW = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_YS_HI   = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_YS_LO   = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_YE_HI   = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_YE_LO   = 4'd9;
    localparam logic [STEP_BITS-1:0] STEP_CMD_WR  = 4'd10;

    // byte positions within a pixel request
    localparam logic [STEP_BITS-1:0] STEP_RED     = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_GREEN   = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_BLUE    = 4'd2;

    typedef struct packed {
        logic [BYTE_BITS-1:0] link_byte;
        logic                 is_data;
        logic                 release_select;
        logic                 last_of_run;
        logic                 bad_window;
    } t_beat;

endpackage

### hw/rtl/lwps_byte_sel.sv
// picks the link byte and its marks for the held request and byte position
// depends on lwps_pkg
module lwps_byte_sel #(
    parameter int COORD_BITS = lwps_pkg::COORD_BITS_DEF
) (
    input  logic                                i_pix,
    input  logic [lwps_pkg::STEP_BITS-1:0]      i_step,
    input  logic [COORD_BITS-1:0]               i_x_start,
    input  logic [COORD_BITS-1:0]               i_x_end,
    input  logic [COORD_BITS-1:0]               i_y_start,
    input  logic [COORD_BITS-1:0]               i_y_end,
    input  logic [4:0]                          i_red5,
    input  logic [5:0]                          i_green6,
    input  logic [4:0]                          i_blue5,
    input  logic [lwps_pkg::BYTE_BITS-1:0]      i_column_cmd,
    input  logic [lwps_pkg::BYTE_BITS-1:0]      i_row_cmd,
    input  logic [lwps_pkg::BYTE_BITS-1:0]      i_write_cmd,
    input  logic                                i_bad,
    input  logic                                i_final_pixel,
    output lwps_pkg::t_beat                     o_beat
);

    logic [15:0] w_xs;
    logic [15:0] w_xe;
    logic [15:0] w_ys;
    logic [15:0] w_ye;

    assign w_xs = 16'(i_x_start);
    assign w_xe = 16'(i_x_end);
    assign w_ys = 16'(i_y_start);
    assign w_ye = 16'(i_y_end);

    always_comb begin
        o_beat = '0;
        if (i_pix) begin
            o_beat.is_data = 1'b1;
            unique case (i_step)
                lwps_pkg::STEP_RED: begin
                    o_beat.link_byte = {i_red5, 3'b000};
                end
                lwps_pkg::STEP_GREEN: begin
                    o_beat.link_byte = {i_green6, 2'b00};
                end
                default: begin
                    o_beat.link_byte      = {i_blue5, 3'b000};
                    o_beat.last_of_run    = 1'b1;
                    o_beat.release_select = i_final_pixel;
                end
            endcase
        end else begin
            o_beat.bad_window = i_bad;
            o_beat.is_data    = 1'b1;
            unique case (i_step)
                lwps_pkg::STEP_CMD_COL: begin
                    o_beat.link_byte = i_column_cmd;
                    o_beat.is_data   = 1'b0;
                end
                lwps_pkg::STEP_XS_HI: o_beat.link_byte = w_xs[15:8];
                lwps_pkg::STEP_XS_LO: o_beat.link_byte = w_xs[7:0];
                lwps_pkg::STEP_XE_HI: o_beat.link_byte = w_xe[15:8];
                lwps_pkg::STEP_XE_LO: begin
                    o_beat.link_byte      = w_xe[7:0];
                    o_beat.release_select = 1'b1;
                end
                lwps_pkg::STEP_CMD_ROW: begin
                    o_beat.link_byte = i_row_cmd;
                    o_beat.is_data   = 1'b0;
                end
                lwps_pkg::STEP_YS_HI: o_beat.link_byte = w_ys[15:8];
                lwps_pkg::STEP_YS_LO: o_beat.link_byte = w_ys[7:0];
                lwps_pkg::STEP_YE_HI: o_beat.link_byte = w_ye[15:8];
                lwps_pkg::STEP_YE_LO: begin
                    o_beat.link_byte      = w_ye[7:0];
                    o_beat.release_select = 1'b1;
                end
                default: begin
                    o_beat.link_byte      = i_write_cmd;
                    o_beat.is_data        = 1'b0;
                    o_beat.release_select = 1'b1;
                    o_beat.last_of_run    = 1'b1;
                end
            endcase
        end
    end

endmodule

### hw/rtl/lcd_window_pixel_streamer.sv
// display link framer: window requests become command/coordinate bytes,
// pixel requests become three data bytes, one per RGB565 colour field.
// Channels: s_axis takes one request per handshake, s_axis_tuser is the
// function (0 window, 1 pixel). m_axis gives one link byte per handshake,
// tuser carries the data/command mark, the select release and the bad
// window flag, tlast marks the final byte of a request.
// A taken request is first held; its first byte then loads the output
// register. Throughput: the output register loads one byte per cycle
// unless m_axis stalls; a window gives 11 bytes, a pixel 3 and a dropped
// pixel (count at zero) none; the next request is taken while the last
// byte of the current one loads. A window sends even when reversed, with
// the count forced to zero.
// Reset (synchronous, active low) clears the pixel count, the held request
// and the output, and restores the command bytes 0x2A, 0x2B and 0x2C.
// A stall on m_axis_tready holds the output byte and the held request
// (a dropped pixel still clears); while a request is held, new requests are
// refused until its last byte loads. Configuration writes are taken at any
// edge with i_cfg_we high and are meant for idle periods.
module lcd_window_pixel_streamer #(
    parameter int COORD_BITS = lwps_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lwps_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [lwps_pkg::BYTE_BITS-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x_start, x_end, y_start, y_end, red5, green6, blue5, zero padding
    input  logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    // func
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // link_byte
    output logic [lwps_pkg::BYTE_BITS-1:0]     m_axis_tdata,
    // is_data, release_select, bad_window
    output logic [2:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int NB  = lwps_pkg::COUNT_BITS;

    logic [lwps_pkg::BYTE_BITS-1:0] r_column_cmd;
    logic [lwps_pkg::BYTE_BITS-1:0] r_row_cmd;
    logic [lwps_pkg::BYTE_BITS-1:0] r_write_cmd;

    // held request
    logic                           r_hv;
    logic                           r_pix;
    logic [lwps_pkg::STEP_BITS-1:0] r_step;
    logic [CB-1:0]                  r_xs;
    logic [CB-1:0]                  r_xe;
    logic [CB-1:0]                  r_ys;
    logic [CB-1:0]                  r_ye;
    logic [4:0]                     r_red5;
    logic [5:0]                     r_green6;
    logic [4:0]                     r_blue5;
    logic                           r_bad;
    logic [DW-1:0]                  r_dx;
    logic [DW-1:0]                  r_dy;
    logic [PW-1:0]                  r_prod;
    logic [NB-1:0]                  r_pixels_left;

    // output register
    logic                           r_mv;
    lwps_pkg::t_beat                r_beat;

    logic [CB-1:0]                  w_in_xs;
    logic [CB-1:0]                  w_in_xe;
    logic [CB-1:0]                  w_in_ys;
    logic [CB-1:0]                  w_in_ye;
    logic                           w_in_bad;
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_drop;
    logic                           w_emit;
    logic                           w_done;
    logic                           w_final_pixel;
    logic [NB-1:0]                  w_count_sat;
    lwps_pkg::t_beat                w_beat;
    logic [NB-1:0]                  n_pixels_left;

    assign w_in_xs  = s_axis_tdata[0*CB +: CB];
    assign w_in_xe  = s_axis_tdata[1*CB +: CB];
    assign w_in_ys  = s_axis_tdata[2*CB +: CB];
    assign w_in_ye  = s_axis_tdata[3*CB +: CB];
    assign w_in_bad = (w_in_xe < w_in_xs) || (w_in_ye < w_in_ys);

    assign w_out_free    = !r_mv || m_axis_tready;
    assign w_drop        = r_hv && r_pix && (r_pixels_left == '0);
    assign w_emit        = r_hv && !w_drop && w_out_free;
    assign w_done        = w_drop || (w_emit && w_beat.last_of_run);
    assign s_axis_tready = !r_hv || w_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_final_pixel = (r_pixels_left == NB'(1));

    generate
        if (PW > NB) begin : g_sat
            assign w_count_sat = (|r_prod[PW-1:NB]) ? {NB{1'b1}} : r_prod[NB-1:0];
        end else begin : g_nosat
            assign w_count_sat = NB'(r_prod);
        end
    endgenerate

    lwps_byte_sel #(
        .COORD_BITS (COORD_BITS)
    ) u_byte_sel (
        .i_pix         (r_pix),
        .i_step        (r_step),
        .i_x_start     (r_xs),
        .i_x_end       (r_xe),
        .i_y_start     (r_ys),
        .i_y_end       (r_ye),
        .i_red5        (r_red5),
        .i_green6      (r_green6),
        .i_blue5       (r_blue5),
        .i_column_cmd  (r_column_cmd),
        .i_row_cmd     (r_row_cmd),
        .i_write_cmd   (r_write_cmd),
        .i_bad         (r_bad),
        .i_final_pixel (w_final_pixel),
        .o_beat        (w_beat)
    );

    // count loads on the write command byte (zero for a bad window), counts down on the blue byte
    always_comb begin
        n_pixels_left = r_pixels_left;
        if (w_emit && w_beat.last_of_run) begin
            if (r_pix) begin
                n_pixels_left = r_pixels_left - NB'(1);
            end else if (r_bad) begin
                n_pixels_left = '0;
            end else begin
                n_pixels_left = w_count_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_cmd <= lwps_pkg::COLUMN_CMD_RST;
            r_row_cmd    <= lwps_pkg::ROW_CMD_RST;
            r_write_cmd  <= lwps_pkg::WRITE_CMD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lwps_pkg::CFG_COLUMN_CMD: r_column_cmd <= i_cfg_data;
                lwps_pkg::CFG_ROW_CMD:    r_row_cmd    <= i_cfg_data;
                lwps_pkg::CFG_WRITE_CMD:  r_write_cmd  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv          <= 1'b0;
            r_pix         <= 1'b0;
            r_step        <= '0;
            r_pixels_left <= '0;
            r_mv          <= 1'b0;
        end else begin
            r_pixels_left <= n_pixels_left;
            if (w_accept) begin
                r_hv   <= 1'b1;
                r_pix  <= s_axis_tuser;
                r_step <= '0;
            end else if (w_done) begin
                r_hv   <= 1'b0;
                r_step <= '0;
            end else if (w_emit) begin
                r_step <= r_step + lwps_pkg::STEP_BITS'(1);
            end
            if (w_emit) begin
                r_mv <= 1'b1;
            end else if (m_axis_tready) begin
                r_mv <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xs     <= w_in_xs;
            r_xe     <= w_in_xe;
            r_ys     <= w_in_ys;
            r_ye     <= w_in_ye;
            r_red5   <= s_axis_tdata[4*CB +: 5];
            r_green6 <= s_axis_tdata[4*CB+5 +: 6];
            r_blue5  <= s_axis_tdata[4*CB+11 +: 5];
            r_bad    <= w_in_bad;
            r_dx     <= DW'(w_in_xe) - DW'(w_in_xs) + DW'(1);
            r_dy     <= DW'(w_in_ye) - DW'(w_in_ys) + DW'(1);
        end
        // product settles long before the write command byte
        r_prod <= PW'(r_dx) * PW'(r_dy);
        if (w_emit) begin
            r_beat <= w_beat;
        end
    end

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_beat.link_byte;
    assign m_axis_tuser  = {r_beat.bad_window, r_beat.release_select, r_beat.is_data};
    assign m_axis_tlast  = r_beat.last_of_run;

endmodule
